>>> rtl/client_address_learning_table_macros.svh
// ----------------------------------------------------------------------------
// Client address learning table: assertion macros
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CLIENT_ADDRESS_LEARNING_TABLE_MACROS_SVH
`define CLIENT_ADDRESS_LEARNING_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CALT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CALT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/calt_pkg.sv
// ----------------------------------------------------------------------------
// Client address learning table package
// Item types, table size, action codes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package calt_pkg;

  // Number of table slots and the width of a slot index.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths fixed by the item format.
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int SLOT_W = 4;
  localparam int VAL_W  = ADDR_W + PORT_W;

  // Action codes.
  localparam logic ACT_LEARN  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] tunnel_addr;
    logic [ADDR_W-1:0] real_addr;
    logic [PORT_W-1:0] real_port;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] found_addr;
    logic [PORT_W-1:0] found_port;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACC,
    ST_LOAD
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic compare;
    logic access;
    logic load;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/calt_ctrl.sv
// ----------------------------------------------------------------------------
// Client address learning table controller
// Steps one item through capture, compare, table access and result load.
// ----------------------------------------------------------------------------
`default_nettype none

`include "client_address_learning_table_macros.svh"

module calt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire calt_pkg::sts_t sts,
  output calt_pkg::cmd_t     cmd
);
  import calt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.access = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        // Wait here until the output register can take the result.
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `CALT_ASSERT_SAME(a_cmd_onehot, 1'b1,
    $onehot0({cmd.capture, cmd.compare, cmd.access, cmd.load}),
    "controller issued more than one command")
  `CALT_ASSERT_SAME(a_load_free, cmd.load, sts.out_free,
    "result loaded while output register still full")
  `CALT_ASSERT_NEXT(a_cmp_then_acc, cmd.compare, cmd.access,
    "table access did not follow the compare")

endmodule

`default_nettype wire

>>> rtl/calt_dp.sv
// ----------------------------------------------------------------------------
// Client address learning table datapath
// Slot keys with valid bits, parallel compare, value memory, output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "client_address_learning_table_macros.svh"

module calt_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire calt_pkg::in_item_t in_item,
  input  wire calt_pkg::cmd_t     cmd,
  output calt_pkg::sts_t          sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output calt_pkg::out_item_t     out_item
);
  import calt_pkg::*;

  // Captured item.
  in_item_t item_r;

  // Slot keys and valid bits; a slot that is not valid is free.
  logic [ADDR_W-1:0] key_r [ENTRIES];
  logic [ENTRIES-1:0] slot_valid_r;

  // Value memory, {real_addr, real_port} per slot.
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [VAL_W-1:0] rd_r;

  // Compare results.
  logic [ENTRIES-1:0] cand;
  logic               hit_c;
  logic [IDX_W-1:0]   idx_c;
  logic               hit_r;
  logic [IDX_W-1:0]   idx_r;
  logic               wr_en;

  // Result formatting.
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  out_item_t               res;
  out_item_t               out_r;
  logic                    out_valid_r;

  // Capture the item at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // Candidate slots: a learn takes a free or equal slot, a lookup an equal one; a zero address has none.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (item_r.tunnel_addr == '0) begin
        cand[i] = 1'b0;
      end else if (item_r.action == ACT_LEARN) begin
        cand[i] = !slot_valid_r[i] || (key_r[i] == item_r.tunnel_addr);
      end else begin
        cand[i] = slot_valid_r[i] && (key_r[i] == item_r.tunnel_addr);
      end
    end
  end

  // Lowest candidate wins.
  always_comb begin
    hit_c = 1'b0;
    idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_c = 1'b1;
        idx_c = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r <= hit_c;
      idx_r <= idx_c;
    end
  end

  assign wr_en = cmd.access && hit_r && (item_r.action == ACT_LEARN);

  // Slot valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (wr_en) begin
      slot_valid_r[idx_r] <= 1'b1;
    end
  end

  // Key write on learn.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r[idx_r] <= item_r.tunnel_addr;
    end
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[idx_r] <= {item_r.real_addr, item_r.real_port};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rd_r <= val_mem[idx_r];
    end
  end

  // Result item.
  assign slot_ext = {{SLOT_W{1'b0}}, idx_r};

  always_comb begin
    res = '0;
    if (hit_r) begin
      res.success = 1'b1;
      res.slot    = slot_ext[SLOT_W-1:0];
      if (item_r.action == ACT_LOOKUP) begin
        res.found_addr = rd_r[VAL_W-1:PORT_W];
        res.found_port = rd_r[PORT_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= res;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

  `CALT_ASSERT_SAME(a_fail_zero, out_valid_r && !out_r.success,
    (out_r.slot == '0) && (out_r.found_addr == '0) && (out_r.found_port == '0),
    "failed result carries nonzero fields")
  `CALT_ASSERT_SAME(a_no_zero_key, wr_en, item_r.tunnel_addr != '0,
    "zero address written into the table")
  `CALT_ASSERT_NEXT(a_learn_sets_valid, wr_en, slot_valid_r[$past(idx_r)],
    "learned slot not marked valid")

endmodule

`default_nettype wire

>>> rtl/client_address_learning_table.sv
// ----------------------------------------------------------------------------
// Client address learning table
// Maps tunnel-side IPv4 addresses to a client's real address and UDP port.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_item) takes learn and
// lookup items; the result channel (out_valid, out_stall, out_item) returns
// exactly one result item per input item, in order. An item is taken on a
// clock edge where valid is high and stall is low.
// An accepted item is captured at the accepting edge, then come the parallel
// compare of all slot keys, the table write or value read, and the output
// register load; the load waits while the output register is still full.
// The controller walks one item through its compare and table-access steps
// at a time, taking the next item only after the result load, and the value
// memory has a single read/write access per item.
// The next item is accepted while a finished result waits in the output
// register; if the receiver stalls, the following result holds inside the
// block and in_stall stays high until the output register frees up.
// Reset: rst_n (synchronous, active low) marks every slot free and empties
// the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module client_address_learning_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire calt_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output calt_pkg::out_item_t     out_item
);
  import calt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  calt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table and result path.
  calt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> dv/client_address_learning_table_test.sv
// ----------------------------------------------------------------------------
// Client address learning table testbench
// Drives learn and lookup items through the valid/stall channels, predicts
// each result with a software copy of the slot table, and checks every result
// field in order. Both sides idle at random, with quiet stretches, a long
// receiver hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
import calt_pkg::*;

// Tracks the table contents and the queue of results still owed by the block.
class calt_scoreboard;
  logic [ADDR_W-1:0] key_slots [ENTRIES];
  logic [VAL_W-1:0]  value_slots [ENTRIES];
  out_item_t         owed_results[$];
  int errors, items, stored, full, zero_addr, hits, misses;

  function new();
    foreach (key_slots[i]) begin
      key_slots[i]   = '0;
      value_slots[i] = '0;
    end
    errors = 0; items = 0; stored = 0; full = 0;
    zero_addr = 0; hits = 0; misses = 0;
  endfunction

  // Updates the table copy for an accepted item and queues its result.
  function void note_input(in_item_t it);
    out_item_t r;
    bit        done;
    r = '0;
    done = 1'b0;
    items++;
    if (it.tunnel_addr == '0) begin
      // Zero is the free marker: rejected on learn, never found on lookup.
      zero_addr++;
    end else if (it.action == ACT_LEARN) begin
      // First slot that is free or already holds this key takes the pair.
      for (int i = 0; i < ENTRIES && !done; i++) begin
        if (key_slots[i] == '0 || key_slots[i] == it.tunnel_addr) begin
          key_slots[i]   = it.tunnel_addr;
          value_slots[i] = {it.real_addr, it.real_port};
          r.success = 1'b1;
          r.slot    = i[SLOT_W-1:0];
          done      = 1'b1;
        end
      end
      if (done) stored++;
      else full++;
    end else begin
      // Lowest matching slot wins.
      for (int i = 0; i < ENTRIES && !done; i++) begin
        if (key_slots[i] == it.tunnel_addr) begin
          r.success = 1'b1;
          r.slot    = i[SLOT_W-1:0];
          {r.found_addr, r.found_port} = value_slots[i];
          done      = 1'b1;
        end
      end
      if (done) hits++;
      else misses++;
    end
    owed_results.push_back(r);
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  local function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compares an accepted result with the oldest owed one.
  function void check_result(out_item_t got);
    out_item_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual %p",
               $time, got);
      errors++;
      return;
    end
    want = owed_results.pop_front();
    compare_field("success", ADDR_W'(want.success), ADDR_W'(got.success));
    compare_field("slot", ADDR_W'(want.slot), ADDR_W'(got.slot));
    compare_field("found_addr", want.found_addr, got.found_addr);
    compare_field("found_port", ADDR_W'(want.found_port), ADDR_W'(got.found_port));
  endfunction
endclass

module client_address_learning_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int CHUNKS      = 15;
  localparam int CHUNK_ITEMS = 125;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  calt_scoreboard   sb;
  logic [ADDR_W-1:0] known_keys[$];
  bit               quiet = 1'b0;
  int               hold_request = 0;
  int               idle_cycles = 0;

  client_address_learning_table DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels; note inputs and check results as they are taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Stop a hung run after a long stretch with nothing accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stall before each result, or a long hold when asked.
  initial begin
    int wait_cycles;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        wait_cycles = quiet ? 0 : $urandom_range(0, 9);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t make_item(logic act, logic [ADDR_W-1:0] taddr,
                                         logic [ADDR_W-1:0] raddr,
                                         logic [PORT_W-1:0] rport);
    in_item_t it;
    it.action      = act;
    it.tunnel_addr = taddr;
    it.real_addr   = raddr;
    it.real_port   = rport;
    return it;
  endfunction

  // Random item: mostly keys already in the table, plus misses, near misses
  // and the zero address.
  function automatic in_item_t random_item();
    logic [ADDR_W-1:0] taddr;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      taddr = known_keys[$urandom_range(0, known_keys.size() - 1)];
    else if (pick < 85)
      taddr = $urandom;
    else if (pick < 92)
      taddr = '0;
    else
      taddr = known_keys[$urandom_range(0, known_keys.size() - 1)]
              ^ (32'd1 << $urandom_range(0, ADDR_W - 1));
    return make_item($urandom_range(0, 1) ? ACT_LOOKUP : ACT_LEARN, taddr,
                     $urandom, PORT_W'($urandom_range(0, 16'hFFFF)));
  endfunction

  // Offers one item after a random gap and holds it until it is taken.
  task automatic send_item(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits until every owed result has arrived. The first
  // edge lets the monitor note the item taken at the previous edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] key;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero address, field extremes, relearn, then fill the table.
    send_item(make_item(ACT_LEARN, '0, 32'hDEADBEEF, 16'h1234));
    send_item(make_item(ACT_LOOKUP, '0, '0, '0));
    send_item(make_item(ACT_LEARN, 32'h1, '0, '0));
    send_item(make_item(ACT_LEARN, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
    send_item(make_item(ACT_LOOKUP, 32'h1, 32'hFFFFFFFF, 16'hFFFF));
    send_item(make_item(ACT_LOOKUP, 32'hFFFFFFFF, '0, '0));
    send_item(make_item(ACT_LOOKUP, 32'h12345678, '0, '0));
    send_item(make_item(ACT_LEARN, 32'h1, 32'hAAAA5555, 16'h5A5A));
    send_item(make_item(ACT_LOOKUP, 32'h1, '0, '0));
    known_keys.push_back(32'h1);
    known_keys.push_back(32'hFFFFFFFF);
    for (int i = 2; i < ENTRIES; i++) begin
      key = $urandom | 32'h1;
      known_keys.push_back(key);
      send_item(make_item(ACT_LEARN, key, $urandom,
                          PORT_W'($urandom_range(0, 16'hFFFF))));
    end
    // The table is now full, so a new key is refused.
    send_item(make_item(ACT_LEARN, 32'hC0FFEE01, 32'h55AA55AA, 16'hA5A5));
    send_item(make_item(ACT_LOOKUP, key, '0, '0));
    wait_drained();

    // Random phases: quiet stretches, a long receiver hold and a drain.
    for (int c = 0; c < CHUNKS; c++) begin
      quiet = (c % 4 == 1) || (c == 5);
      if (c == 5) hold_request = HOLD_CYCLES;
      for (int n = 0; n < CHUNK_ITEMS; n++) send_item(random_item());
      if (c == 8) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d items: %0d learns stored, %0d refused as full, %0d zero address;",
             sb.items, sb.stored, sb.full, sb.zero_addr);
    $display("lookups found %0d and missed %0d, with random idling on both sides.",
             sb.hits, sb.misses);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
